FILE: sv/sso_pkg.sv
// Shared types, constants and helper functions of the skid-steer odometry block.
package sso_pkg;

	localparam int FRAC_BITS = 16;
	localparam int HEAD_W    = 19;
	localparam int MUL_AW    = 34;
	localparam int MUL_BW    = 32;
	localparam int MUL_PW    = MUL_AW + MUL_BW;
	localparam int DIV_NW    = 64;
	localparam int COR_W     = 34;
	localparam int COR_ZW    = 35;

	localparam longint PI_Q24      = 64'd52707179;
	localparam longint PI_FX       =
		(PI_Q24 + ((64'd1 << (24 - FRAC_BITS)) >> 1)) >> (24 - FRAC_BITS);
	localparam longint TWO_PI_FX   = 2 * PI_FX;
	localparam longint PI_Q30      = 64'd3373259426;
	localparam longint HALF_PI_Q30 = 64'd1686629713;
	localparam longint GAIN_Q30    = 64'd652032874;
	localparam longint US_PER_S    = 64'd1000000;
	localparam longint MAX_DT      = 64'd2147483647;

	localparam int CFG_W = 20;

	typedef enum logic [1:0] {
		CFG_SEPARATION = 2'd0,
		CFG_LEFT_RADIUS = 2'd1,
		CFG_RIGHT_RADIUS = 2'd2,
		CFG_UNUSED = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_WHEEL = 2'd0,
		MODE_OPEN  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_TIME  = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_L,
		ST_MUL_R,
		ST_DIST,
		ST_DIV_ANG,
		ST_OL_MUL_L,
		ST_OL_DIV_L,
		ST_OL_MUL_A,
		ST_OL_DIV_A,
		ST_WRAP,
		ST_CORDIC,
		ST_MUL_X,
		ST_MUL_Y,
		ST_RATE_L,
		ST_RATE_A,
		ST_DONE
	} state_t;

	// Arctangent of 2^-i in Q30, truncated for i up to 26.
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// Magnitude of a signed value.
	function automatic logic [39:0] mag40(input logic signed [39:0] v);
		return v[39] ? 40'(-v) : 40'(v);
	endfunction

	// Floor of (sign * mag) / 2^k as a signed value.
	function automatic logic signed [MUL_PW-1:0] floor_shr(input logic neg,
		input logic [MUL_PW-1:0] mag, input int unsigned k);
		logic [MUL_PW-1:0] m1;
		m1 = mag - MUL_PW'(1);
		if (neg && (mag != '0))
			return $signed(~(m1 >> k));
		else
			return $signed(mag >> k);
	endfunction

	// Apply sign to a magnitude and clamp to 32-bit signed.
	function automatic logic signed [31:0] sat_mag(input logic neg,
		input logic [DIV_NW-1:0] mag);
		if (neg) begin
			if (mag > DIV_NW'(64'h80000000))
				return $signed(32'h80000000);
			else
				return $signed(~mag[31:0] + 32'd1);
		end else begin
			if (mag > DIV_NW'(64'h7FFFFFFF))
				return $signed(32'h7FFFFFFF);
			else
				return $signed(mag[31:0]);
		end
	endfunction

	// Clamp a signed value to 32-bit signed.
	function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return $signed(32'h7FFFFFFF);
		else if (v < -40'sd2147483648)
			return $signed(32'h80000000);
		else
			return $signed(v[31:0]);
	endfunction

endpackage

FILE: sv/sso_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module sso_mul
	import sso_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MUL_AW-1:0] a,
	input  logic [MUL_BW-1:0] b,
	output logic              done,
	output logic [MUL_PW-1:0] prod
);

	localparam int CW = $clog2(MUL_BW);

	logic [MUL_AW-1:0] a_q;
	logic [MUL_PW-1:0] p_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_AW:0]   sum;

	assign sum  = {1'b0, p_q[MUL_PW-1:MUL_BW]} + (p_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_AW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MUL_BW-1:1]};
		end
	end

endmodule

FILE: sv/sso_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module sso_div
	import sso_pkg::*;
#(
	parameter int DW = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DW-1:0]     den,
	output logic              done,
	output logic [DIV_NW-1:0] quo,
	output logic [DW-1:0]     rem
);

	localparam int CW = $clog2(DIV_NW);

	logic [DW-1:0]     den_q;
	logic [DW-1:0]     rem_q;
	logic [DIV_NW-1:0] nq_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DW:0]       shifted;
	logic [DW+1:0]     trial;
	logic              fits;

	assign shifted = {rem_q, nq_q[DIV_NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign fits    = !trial[DW+1];
	assign done    = done_q;
	assign quo     = nq_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			nq_q  <= num;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DW-1:0] : shifted[DW-1:0];
			nq_q  <= {nq_q[DIV_NW-2:0], fits};
		end
	end

endmodule

FILE: sv/sso_cordic.sv
// Iterative CORDIC rotator giving cosine and sine of the heading in Q30.
module sso_cordic
	import sso_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [HEAD_W-1:0] angle,
	output logic                     done,
	output logic signed [COR_W-1:0]  cos_v,
	output logic signed [COR_W-1:0]  sin_v
);

	localparam int CW = $clog2(CORDIC_STEPS);

	logic signed [COR_W-1:0]  x_q, y_q;
	logic signed [COR_ZW-1:0] z_q;
	logic                     neg_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [COR_ZW-1:0] z0;
	logic signed [COR_W-1:0]  sx, sy;
	logic signed [COR_ZW-1:0] at;

	assign z0    = COR_ZW'(angle) <<< (30 - FRAC_BITS);
	assign sx    = x_q >>> cnt_q;
	assign sy    = y_q >>> cnt_q;
	assign at    = $signed(COR_ZW'(atan_q30(5'(cnt_q))));
	assign done  = done_q;
	assign cos_v = neg_q ? -x_q : x_q;
	assign sin_v = neg_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= COR_W'(GAIN_Q30);
			y_q <= '0;
			// fold the angle into the right half plane
			if (z0 > COR_ZW'(HALF_PI_Q30)) begin
				z_q   <= z0 - COR_ZW'(PI_Q30);
				neg_q <= 1'b1;
			end else if (z0 < -COR_ZW'(HALF_PI_Q30)) begin
				z_q   <= z0 + COR_ZW'(PI_Q30);
				neg_q <= 1'b1;
			end else begin
				z_q   <= z0;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - sy;
				y_q <= y_q + sx;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + sy;
				y_q <= y_q - sx;
				z_q <= z_q + at;
			end
		end
	end

endmodule

FILE: sv/skid_steer_odometry.sv
// Top level of the skid-steer odometry block: sequencer, pose state and result register.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+---------------------------------------------
//   item     | item_valid / item_stall    | mode, four wheel angles, commands, sample_time
//   result   | result_valid / result_stall| pose, heading, rates, time_error
//   config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One sequencer walks each wheel or open-loop word through a bit-serial multiplier,
// a bit-serial divider and an iterative CORDIC; reset-pose and set-time words use
// none of them. The serial divider dominates the run time. item_stall is high from the
// accept until the result is loaded. The result register holds its word under
// result_stall; the sequencer waits at its end only if that register is still full.
// Reset clears pose, rates, last angles and time, and loads the register defaults.
module skid_steer_odometry
	import sso_pkg::*;
#(
	parameter int CORDIC_STEPS = 16,
	parameter int TIME_WIDTH   = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               mode,
	input  logic signed [31:0]       left_front_angle,
	input  logic signed [31:0]       left_rear_angle,
	input  logic signed [31:0]       right_front_angle,
	input  logic signed [31:0]       right_rear_angle,
	input  logic signed [31:0]       cmd_linear,
	input  logic signed [31:0]       cmd_angular,
	input  logic [TIME_WIDTH-1:0]    sample_time,

	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [31:0]       pose_x_out,
	output logic signed [31:0]       pose_y_out,
	output logic signed [HEAD_W-1:0] heading_out,
	output logic signed [31:0]       linear_rate_out,
	output logic signed [31:0]       angular_rate_out,
	output logic                     time_error,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int TW = TIME_WIDTH;

	state_t state_q, state_d;
	logic   issued_q;

	// configuration
	logic [19:0] sep_q;
	logic [15:0] lrad_q, rrad_q;

	// latched word
	mode_t              mode_q;
	logic signed [31:0] lf_q, lr_q, rf_q, rr_q, cl_q, ca_q;
	logic [TW-1:0]      now_q;

	// architectural state
	logic signed [31:0]       pose_x_q, pose_y_q, lin_rate_q, ang_rate_q;
	logic signed [HEAD_W-1:0] heading_q;
	logic signed [31:0]       last_l_q, last_r_q;
	logic [TW-1:0]            last_time_q;

	// working registers
	logic [TW-1:0]      d_q;
	logic               terr_q;
	logic [30:0]        dtc_q;
	logic signed [32:0] dl_q, dr_q;
	logic signed [33:0] lt_q, rt_q;
	logic signed [31:0] dist_q, dang_q;
	logic signed [34:0] diff_q;

	// result register
	logic                     res_valid_q;
	logic signed [31:0]       res_x_q, res_y_q, res_lin_q, res_ang_q;
	logic signed [HEAD_W-1:0] res_head_q;
	logic                     res_terr_q;

	// unit hookup
	logic              mul_start, mul_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_prod;
	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [TW-1:0]     div_den, div_rem;
	logic              cor_start, cor_done;
	logic signed [COR_W-1:0] cos_v, sin_v;

	// combinational datapath
	logic                     accept;
	logic                     load_res;
	logic [TW-1:0]            d_now;
	logic                     terr_now;
	logic signed [31:0]       la, ra;
	logic signed [32:0]       lsum, rsum;
	logic                     mul_neg;
	logic signed [MUL_PW-1:0] mul_val;
	logic signed [39:0]       pose_sum;
	logic signed [34:0]       side_sum;
	logic signed [32:0]       a_sum;
	logic signed [20:0]       wrap_r;
	logic signed [20:0]       wrap_adj;

	assign accept   = item_valid && !item_stall;
	assign load_res = !res_valid_q || !result_stall;
	assign cfg_ready = 1'b1;

	assign result_valid     = res_valid_q;
	assign pose_x_out       = res_x_q;
	assign pose_y_out       = res_y_q;
	assign heading_out      = res_head_q;
	assign linear_rate_out  = res_lin_q;
	assign angular_rate_out = res_ang_q;
	assign time_error       = res_terr_q;

	sso_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	sso_div #(.DW(TW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	sso_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (heading_q),
		.done   (cor_done),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept) state_d = ST_PREP;
			ST_PREP: begin
				unique case (mode_q)
					MODE_WHEEL: state_d = ST_MUL_L;
					MODE_OPEN:  state_d = ST_OL_MUL_L;
					MODE_CLEAR: state_d = ST_DONE;
					MODE_TIME:  state_d = ST_DONE;
				endcase
			end
			ST_MUL_L:    if (mul_done) state_d = ST_MUL_R;
			ST_MUL_R:    if (mul_done) state_d = ST_DIST;
			ST_DIST:     state_d = ST_DIV_ANG;
			ST_DIV_ANG:  if (div_done) state_d = ST_WRAP;
			ST_OL_MUL_L: if (mul_done) state_d = ST_OL_DIV_L;
			ST_OL_DIV_L: if (div_done) state_d = ST_OL_MUL_A;
			ST_OL_MUL_A: if (mul_done) state_d = ST_OL_DIV_A;
			ST_OL_DIV_A: if (div_done) state_d = ST_WRAP;
			ST_WRAP:     if (div_done) state_d = ST_CORDIC;
			ST_CORDIC:   if (cor_done) state_d = ST_MUL_X;
			ST_MUL_X:    if (mul_done) state_d = ST_MUL_Y;
			ST_MUL_Y: begin
				if (mul_done)
					state_d = (mode_q == MODE_WHEEL && !terr_q) ? ST_RATE_L : ST_DONE;
			end
			ST_RATE_L:   if (div_done) state_d = ST_RATE_A;
			ST_RATE_A:   if (div_done) state_d = ST_DONE;
			ST_DONE:     if (load_res) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall = (state_q != ST_IDLE);
		mul_start  = 1'b0;
		div_start  = 1'b0;
		cor_start  = 1'b0;
		unique case (state_q)
			ST_MUL_L, ST_MUL_R, ST_OL_MUL_L, ST_OL_MUL_A, ST_MUL_X, ST_MUL_Y:
				mul_start = !issued_q;
			ST_DIV_ANG, ST_OL_DIV_L, ST_OL_DIV_A, ST_WRAP, ST_RATE_L, ST_RATE_A:
				div_start = !issued_q;
			ST_CORDIC:
				cor_start = !issued_q;
			default: ;
		endcase
	end

	// operand selection and result shaping
	always_comb begin
		d_now    = now_q - last_time_q;
		terr_now = (d_now == '0) || d_now[TW-1];
		lsum     = 33'(lf_q) + 33'(lr_q);
		rsum     = 33'(rf_q) + 33'(rr_q);
		la       = 32'(lsum >>> 1);
		ra       = 32'(rsum >>> 1);
		side_sum = 35'(lt_q) + 35'(rt_q);
		a_sum    = 33'(heading_q) + 33'(dang_q);

		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		div_num = '0;
		div_den = TW'(1);
		unique case (state_q)
			ST_MUL_L: begin
				mul_a   = MUL_AW'(mag40(40'(dl_q)));
				mul_b   = MUL_BW'(lrad_q);
				mul_neg = dl_q[32];
			end
			ST_MUL_R: begin
				mul_a   = MUL_AW'(mag40(40'(dr_q)));
				mul_b   = MUL_BW'(rrad_q);
				mul_neg = dr_q[32];
			end
			ST_OL_MUL_L: begin
				mul_a = MUL_AW'(mag40(40'(cl_q)));
				mul_b = MUL_BW'(dtc_q);
			end
			ST_OL_MUL_A: begin
				mul_a = MUL_AW'(mag40(40'(ca_q)));
				mul_b = MUL_BW'(dtc_q);
			end
			ST_MUL_X: begin
				mul_a   = MUL_AW'(mag40(40'(dist_q)));
				mul_b   = MUL_BW'(mag40(40'(cos_v)));
				mul_neg = dist_q[31] ^ cos_v[COR_W-1];
			end
			ST_MUL_Y: begin
				mul_a   = MUL_AW'(mag40(40'(dist_q)));
				mul_b   = MUL_BW'(mag40(40'(sin_v)));
				mul_neg = dist_q[31] ^ sin_v[COR_W-1];
			end
			ST_DIV_ANG: begin
				// scale the travel difference up by the fraction before dividing
				div_num = DIV_NW'({mag40(40'(diff_q)), 16'h0000});
				div_den = (sep_q == '0) ? TW'(1) : TW'(sep_q);
			end
			ST_OL_DIV_L, ST_OL_DIV_A: begin
				div_num = DIV_NW'(mul_prod);
				div_den = TW'(US_PER_S);
			end
			ST_WRAP: begin
				div_num = DIV_NW'(mag40(40'(a_sum)));
				div_den = TW'(TWO_PI_FX);
			end
			ST_RATE_L: begin
				div_num = DIV_NW'(mag40(40'(dist_q))) * DIV_NW'(US_PER_S);
				div_den = d_q;
			end
			ST_RATE_A: begin
				div_num = DIV_NW'(mag40(40'(dang_q))) * DIV_NW'(US_PER_S);
				div_den = d_q;
			end
			default: ;
		endcase

		mul_val  = floor_shr(mul_neg, mul_prod,
			(state_q == ST_MUL_X || state_q == ST_MUL_Y) ? 30 : 16);
		pose_sum = $signed(mul_val[39:0]) +
			((state_q == ST_MUL_Y) ? 40'(pose_y_q) : 40'(pose_x_q));

		// remainder carries the sign of the dividend, then fold into (-pi, pi]
		wrap_r = a_sum[32] ? -$signed({1'b0, div_rem[19:0]}) : $signed({1'b0, div_rem[19:0]});
		if (wrap_r > 21'(PI_FX))
			wrap_adj = wrap_r - 21'(TWO_PI_FX);
		else if (wrap_r <= -21'(PI_FX))
			wrap_adj = wrap_r + 21'(TWO_PI_FX);
		else
			wrap_adj = wrap_r;
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			res_valid_q <= 1'b0;
			sep_q       <= 20'd32768;
			lrad_q      <= '0;
			rrad_q      <= '0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			heading_q   <= '0;
			lin_rate_q  <= '0;
			ang_rate_q  <= '0;
			last_l_q    <= '0;
			last_r_q    <= '0;
			last_time_q <= '0;
			terr_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			if (mul_start || div_start || cor_start)
				issued_q <= 1'b1;
			else if (mul_done || div_done || cor_done)
				issued_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_SEPARATION:   sep_q  <= cfg_data;
					CFG_LEFT_RADIUS:  lrad_q <= cfg_data[15:0];
					CFG_RIGHT_RADIUS: rrad_q <= cfg_data[15:0];
					CFG_UNUSED: ;
				endcase
			end

			unique case (state_q)
				ST_PREP: begin
					terr_q <= (mode_q == MODE_WHEEL || mode_q == MODE_OPEN) && terr_now;
					unique case (mode_q)
						MODE_WHEEL: begin
							last_l_q    <= la;
							last_r_q    <= ra;
							last_time_q <= now_q;
						end
						MODE_OPEN: begin
							lin_rate_q  <= cl_q;
							ang_rate_q  <= ca_q;
							last_time_q <= now_q;
						end
						MODE_CLEAR: begin
							pose_x_q  <= '0;
							pose_y_q  <= '0;
							heading_q <= '0;
						end
						MODE_TIME: last_time_q <= now_q;
					endcase
				end
				ST_WRAP:  if (div_done) heading_q <= HEAD_W'(wrap_adj);
				ST_MUL_X: if (mul_done) pose_x_q <= sat40(pose_sum);
				ST_MUL_Y: if (mul_done) pose_y_q <= sat40(pose_sum);
				ST_RATE_L: if (div_done) lin_rate_q <= sat_mag(dist_q[31], div_quo);
				ST_RATE_A: if (div_done) ang_rate_q <= sat_mag(dang_q[31], div_quo);
				default: ;
			endcase

			// hold the result word until taken; drop valid once it leaves
			if (state_q == ST_DONE && load_res)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			lf_q   <= left_front_angle;
			lr_q   <= left_rear_angle;
			rf_q   <= right_front_angle;
			rr_q   <= right_rear_angle;
			cl_q   <= cmd_linear;
			ca_q   <= cmd_angular;
			now_q  <= sample_time;
		end

		unique case (state_q)
			ST_PREP: begin
				d_q  <= d_now;
				dl_q <= 33'(la) - 33'(last_l_q);
				dr_q <= 33'(ra) - 33'(last_r_q);
				if (terr_now)
					dtc_q <= '0;
				else if (d_now > TW'(MAX_DT))
					dtc_q <= 31'(MAX_DT);
				else
					dtc_q <= d_now[30:0];
			end
			ST_MUL_L: if (mul_done) lt_q <= $signed(mul_val[33:0]);
			ST_MUL_R: if (mul_done) rt_q <= $signed(mul_val[33:0]);
			ST_DIST: begin
				dist_q <= sat40(40'(side_sum >>> 1));
				diff_q <= 35'(rt_q) - 35'(lt_q);
			end
			ST_DIV_ANG:  if (div_done) dang_q <= sat_mag(diff_q[34], div_quo);
			ST_OL_DIV_L: if (div_done) dist_q <= sat_mag(cl_q[31], div_quo);
			ST_OL_DIV_A: if (div_done) dang_q <= sat_mag(ca_q[31], div_quo);
			default: ;
		endcase

		if (state_q == ST_DONE && load_res) begin
			res_x_q    <= pose_x_q;
			res_y_q    <= pose_y_q;
			res_head_q <= heading_q;
			res_lin_q  <= lin_rate_q;
			res_ang_q  <= ang_rate_q;
			res_terr_q <= terr_q;
		end
	end

endmodule
